>>> design/tlsf_pkg.sv
// ----------------------------------------------------------------------------
// TLSF bitmap index package
// Shared types, codes and size-mapping helpers of the two-level bitmap index.
// ----------------------------------------------------------------------------
package tlsf_pkg;

	localparam int FL_COUNT   = 26;
	localparam int SL_LOG2    = 5;
	localparam int SMALL_LOG2 = 8;

	localparam int SL_COUNT = 1 << SL_LOG2;
	localparam int FL_AW    = $clog2(FL_COUNT);
	localparam logic [31:0] SMALL_SIZE = 32'd1 << SMALL_LOG2;

	localparam logic [1:0] OP_FIND  = 2'd0;
	localparam logic [1:0] OP_SET   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] ST_FIT   = 2'd0;
	localparam logic [1:0] ST_EXACT = 2'd1;
	localparam logic [1:0] ST_NONE  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] size;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] first_index;
		logic [4:0] second_index;
	} rsp_t;

	typedef enum logic [1:0] {
		K_FIND   = 2'd0,
		K_SET    = 2'd1,
		K_CLR    = 2'd2,
		K_REJECT = 2'd3
	} kind_t;

	typedef struct packed {
		logic [4:0]         fl;
		logic [SL_LOG2-1:0] sl;
	} map_t;

	typedef struct packed {
		kind_t              kind;
		logic [4:0]         fl;
		logic [SL_LOG2-1:0] sl;
		logic [4:0]         efl;
		logic [SL_LOG2-1:0] esl;
	} cmd_t;

	function automatic logic [4:0] high_bit(logic [31:0] v);
		logic [4:0] n;
		n = '0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) begin
				n = 5'(i);
			end
		end
		return n;
	endfunction

	function automatic logic [4:0] low_bit(logic [31:0] v);
		logic [4:0] n;
		n = '0;
		for (int i = 31; i >= 0; i--) begin
			if (v[i]) begin
				n = 5'(i);
			end
		end
		return n;
	endfunction

	// Maps a size with highest set bit hb to its first and second level list.
	function automatic map_t map_size(logic [31:0] v, logic [4:0] hb);
		logic [31+SL_LOG2:0] ext;
		map_t m;
		ext = {v, {SL_LOG2{1'b0}}};
		if (v < SMALL_SIZE) begin
			m.fl = '0;
			m.sl = SL_LOG2'(ext >> SMALL_LOG2);
		end else begin
			m.fl = hb - 5'(SMALL_LOG2 - 1);
			m.sl = SL_LOG2'(ext >> hb);
		end
		return m;
	endfunction

endpackage

>>> design/tlsf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tlsf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/tlsf_front.sv
// ----------------------------------------------------------------------------
// TLSF front end
// Maps each request to its lists, rounding a find's size up first, and queues the classified command.
// ----------------------------------------------------------------------------
module tlsf_front import tlsf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic cmd_valid,
	output cmd_t cmd,
	input  logic cmd_pop
);

	cmd_t        fifo_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	cmd_t        cmd_in;
	logic [4:0]  f;
	logic [4:0]  rf;
	logic        round_en;
	logic [32:0] inc;
	logic [32:0] rounded;
	logic [32:0] rtop;
	map_t        exact;
	map_t        rmap;

	always_comb begin
		f        = high_bit(req.size);
		exact    = map_size(req.size, f);
		round_en = (req.size > SMALL_SIZE) && (f >= 5'(SL_LOG2));
		inc      = round_en ? ((33'd1 << (f - 5'(SL_LOG2))) - 33'd1) : '0;
		rounded  = {1'b0, req.size} + inc;
		rtop     = rounded >> f;
		rf       = f + {4'b0, rtop[1]};
		rmap     = map_size(rounded[31:0], rf);

		cmd_in.kind = K_REJECT;
		cmd_in.fl   = exact.fl;
		cmd_in.sl   = exact.sl;
		cmd_in.efl  = exact.fl;
		cmd_in.esl  = exact.sl;
		unique case (req.op)
			OP_FIND: begin
				cmd_in.fl = rmap.fl;
				cmd_in.sl = rmap.sl;
				if (!rounded[32] && ({1'b0, rmap.fl} < 6'(FL_COUNT))) begin
					cmd_in.kind = K_FIND;
				end
			end
			OP_SET: begin
				if ({1'b0, exact.fl} < 6'(FL_COUNT)) begin
					cmd_in.kind = K_SET;
				end
			end
			OP_CLEAR: begin
				if ({1'b0, exact.fl} < 6'(FL_COUNT)) begin
					cmd_in.kind = K_CLR;
				end
			end
			default: begin
				cmd_in.kind = K_REJECT;
			end
		endcase
	end

	assign req_stall = (count_q == 2'd2);
	assign push      = req_valid && !req_stall;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= 2'(count_q + {1'b0, push} - {1'b0, cmd_pop});
		end
	end

endmodule

>>> design/tlsf_back.sv
// ----------------------------------------------------------------------------
// TLSF back end
// Searches and updates the two bitmap levels and registers each response.
// ----------------------------------------------------------------------------
module tlsf_back import tlsf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_FIND  = 5'b00010,
		S_NEXT  = 5'b00100,
		S_EXACT = 5'b01000,
		S_MARK  = 5'b10000
	} state_t;

	state_t               state_q, state_d;
	cmd_t                 cur_q, cur_d;
	logic [FL_COUNT-1:0]  top_q, top_d;
	logic [FL_COUNT-1:0]  valid_q, valid_d;
	logic                 rd_vld_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q, rsp_d;
	logic                 emit;
	logic                 rsp_free;
	logic                 re;
	logic                 we;
	logic [FL_AW-1:0]     raddr;
	logic [FL_AW-1:0]     waddr;
	logic [SL_COUNT-1:0]  wdata;
	logic [SL_COUNT-1:0]  rdata;
	logic [SL_COUNT-1:0]  row;
	logic [SL_COUNT-1:0]  bm;
	logic [SL_COUNT-1:0]  bit_mask;
	logic [FL_COUNT-1:0]  topbits;
	logic [4:0]           fl2;
	logic                 exact_hit;

	tlsf_ram #(
		.WIDTH (SL_COUNT),
		.DEPTH (FL_COUNT)
	) u_sub_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		row      = rd_vld_q ? rdata : '0;
		bm       = row & ({SL_COUNT{1'b1}} << cur_q.sl);
		bit_mask = SL_COUNT'(1) << cur_q.sl;
		for (int i = 0; i < FL_COUNT; i++) begin
			topbits[i] = top_q[i] && (5'(i) > cur_q.fl);
		end
		fl2       = low_bit(32'(topbits));
		exact_hit = ({1'b0, cur_q.efl} < 6'(FL_COUNT)) && row[cur_q.esl];
		rsp_free  = !rsp_valid_q || !rsp_stall;

		state_d = state_q;
		cur_d   = cur_q;
		top_d   = top_q;
		valid_d = valid_q;
		cmd_pop = 1'b0;
		re      = 1'b0;
		raddr   = cmd.fl[FL_AW-1:0];
		we      = 1'b0;
		waddr   = cur_q.fl[FL_AW-1:0];
		wdata   = (cur_q.kind == K_SET) ? (row | bit_mask) : (row & ~bit_mask);
		emit    = 1'b0;
		rsp_d   = '0;

		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					if (cmd.kind == K_REJECT) begin
						if (rsp_free) begin
							emit         = 1'b1;
							rsp_d.status = ST_RANGE;
							cmd_pop      = 1'b1;
						end
					end else begin
						re      = 1'b1;
						cmd_pop = 1'b1;
						cur_d   = cmd;
						state_d = (cmd.kind == K_FIND) ? S_FIND : S_MARK;
					end
				end
			end
			S_FIND: begin
				if (bm != '0) begin
					if (rsp_free) begin
						emit               = 1'b1;
						rsp_d.status       = ST_FIT;
						rsp_d.first_index  = cur_q.fl;
						rsp_d.second_index = low_bit(32'(bm));
						state_d            = S_IDLE;
					end
				end else if (topbits != '0) begin
					re       = 1'b1;
					raddr    = fl2[FL_AW-1:0];
					cur_d.fl = fl2;
					state_d  = S_NEXT;
				end else begin
					re      = 1'b1;
					raddr   = cur_q.efl[FL_AW-1:0];
					state_d = S_EXACT;
				end
			end
			S_NEXT: begin
				if (rsp_free) begin
					emit               = 1'b1;
					rsp_d.status       = ST_FIT;
					rsp_d.first_index  = cur_q.fl;
					rsp_d.second_index = low_bit(32'(row));
					state_d            = S_IDLE;
				end
			end
			S_EXACT: begin
				if (rsp_free) begin
					emit               = 1'b1;
					rsp_d.status       = exact_hit ? ST_EXACT : ST_NONE;
					rsp_d.first_index  = cur_q.efl;
					rsp_d.second_index = 5'(cur_q.esl);
					state_d            = S_IDLE;
				end
			end
			S_MARK: begin
				if (rsp_free) begin
					we                                = 1'b1;
					valid_d[cur_q.fl[FL_AW-1:0]]      = 1'b1;
					if (cur_q.kind == K_SET) begin
						top_d[cur_q.fl[FL_AW-1:0]] = 1'b1;
					end else if (wdata == '0) begin
						top_d[cur_q.fl[FL_AW-1:0]] = 1'b0;
					end
					emit               = 1'b1;
					rsp_d.status       = ST_FIT;
					rsp_d.first_index  = cur_q.fl;
					rsp_d.second_index = 5'(cur_q.sl);
					state_d            = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		if (emit) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			top_q       <= '0;
			valid_q     <= '0;
			rd_vld_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			top_q   <= top_d;
			valid_q <= valid_d;
			if (re) begin
				rd_vld_q <= valid_q[raddr];
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> design/tlsf_free_list_bitmap_index_top.sv
// ----------------------------------------------------------------------------
// TLSF free-list bitmap index
// A request enters a two-entry command queue and the response is registered.
// Out-of-range requests are answered without a bitmap read, marks and finds that
// hit the requested class read one row, and finds that go on to a higher class or
// to the exact-size list read a second row. One command is served at a time,
// through the single read port of the second-level RAM. Reset clears both bitmaps
// at once through per-row valid bits and empties the queue and response register.
// ----------------------------------------------------------------------------
module tlsf_free_list_bitmap_index_top import tlsf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	tlsf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	tlsf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
